/* rtl/core/lpg_pkg.sv */
// Shared constants and control types for the line pixel generator.
package lpg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 16;
  localparam int APB_DATA_BITS  = 32;
  localparam int APB_ADDR_BITS  = 3;
  localparam int REG_IDX_BITS   = APB_ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_DRAW_COLOR = '0;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef struct packed {
    logic load;
    logic step;
  } lpg_cmd_t;

  typedef struct packed {
    logic last;
  } lpg_sts_t;

endpackage

/* rtl/core/lpg_item_if.sv */
// Input channel carrying load and step commands with line endpoints.
interface lpg_item_if #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, input ready);
  modport sink (input valid, cmd, x_start, y_start, x_end, y_end, output ready);
endinterface

/* rtl/core/lpg_pixel_if.sv */
// Output channel carrying rasterized pixels.
interface lpg_pixel_if #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic [COORD_BITS-1:0]             pixel_x;
  logic [COORD_BITS-1:0]             pixel_y;
  logic [lpg_pkg::COLOR_BITS-1:0]    pixel_color;
  logic                              last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

/* rtl/core/lpg_datapath.sv */
// Line setup, error accumulation and pixel output registers.
module lpg_datapath #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  lpg_pkg::lpg_cmd_t              ctl,
  output lpg_pkg::lpg_sts_t              sts,
  input  logic [COORD_BITS-1:0]          x_start,
  input  logic [COORD_BITS-1:0]          y_start,
  input  logic [COORD_BITS-1:0]          x_end,
  input  logic [COORD_BITS-1:0]          y_end,
  input  logic [lpg_pkg::COLOR_BITS-1:0] draw_color,
  output logic [COORD_BITS-1:0]          pixel_x,
  output logic [COORD_BITS-1:0]          pixel_y,
  output logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                           last
);
  import lpg_pkg::*;

  localparam int EW = COORD_BITS + 1;

  logic [COORD_BITS-1:0] cur_col, cur_row;
  logic [EW-1:0]         err_col, err_row;
  logic [COORD_BITS-1:0] abs_dx, abs_dy, major_len;
  logic [1:0]            dir_col, dir_row;
  logic [EW-1:0]         pixels_left;

  logic [COORD_BITS-1:0] dx_next, dy_next, major_next;
  logic [1:0]            dir_col_next, dir_row_next;
  logic [EW-1:0]         sum_col, sum_row;
  logic [EW-1:0]         err_col_next, err_row_next;
  logic [COORD_BITS-1:0] cur_col_next, cur_row_next;

  always_comb begin
    if (x_end > x_start) begin
      dx_next      = x_end - x_start;
      dir_col_next = DIR_POS;
    end else if (x_end < x_start) begin
      dx_next      = x_start - x_end;
      dir_col_next = DIR_NEG;
    end else begin
      dx_next      = '0;
      dir_col_next = DIR_NONE;
    end
    if (y_end > y_start) begin
      dy_next      = y_end - y_start;
      dir_row_next = DIR_POS;
    end else if (y_end < y_start) begin
      dy_next      = y_start - y_end;
      dir_row_next = DIR_NEG;
    end else begin
      dy_next      = '0;
      dir_row_next = DIR_NONE;
    end
    major_next = (dx_next > dy_next) ? dx_next : dy_next;
  end

  always_comb begin
    sum_col      = err_col + EW'(abs_dx);
    sum_row      = err_row + EW'(abs_dy);
    err_col_next = sum_col;
    err_row_next = sum_row;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    if (sum_col > EW'(major_len)) begin
      err_col_next = sum_col - EW'(major_len);
      unique case (dir_col)
        DIR_POS: cur_col_next = cur_col + COORD_BITS'(1);
        DIR_NEG: cur_col_next = cur_col - COORD_BITS'(1);
        default: cur_col_next = cur_col;
      endcase
    end
    if (sum_row > EW'(major_len)) begin
      err_row_next = sum_row - EW'(major_len);
      unique case (dir_row)
        DIR_POS: cur_row_next = cur_row + COORD_BITS'(1);
        DIR_NEG: cur_row_next = cur_row - COORD_BITS'(1);
        default: cur_row_next = cur_row;
      endcase
    end
  end

  assign sts.last = (pixels_left == EW'(1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      abs_dx      <= dx_next;
      abs_dy      <= dy_next;
      dir_col     <= dir_col_next;
      dir_row     <= dir_row_next;
      major_len   <= major_next;
      cur_col     <= x_start;
      cur_row     <= y_start;
      err_col     <= '0;
      err_row     <= '0;
      pixels_left <= EW'(major_next) + EW'(2);
    end else if (ctl.step) begin
      pixel_x     <= cur_col;
      pixel_y     <= cur_row;
      pixel_color <= draw_color;
      last        <= sts.last;
      err_col     <= err_col_next;
      err_row     <= err_row_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      pixels_left <= pixels_left - EW'(1);
    end
  end

endmodule

/* rtl/core/lpg_ctrl.sv */
// Controller that tracks the active line and the output beat register.
module lpg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lpg_pkg::lpg_cmd_t  ctl,
  input  lpg_pkg::lpg_sts_t  sts
);
  import lpg_pkg::*;

  typedef enum logic {S_IDLE, S_DRAW} state_t;

  state_t state;
  logic   accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign ctl.load = accept && (in_cmd == CMD_LOAD);
  assign ctl.step = accept && (in_cmd == CMD_STEP) && (state == S_DRAW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load) begin
        state <= S_DRAW;
      end else if (ctl.step && sts.last) begin
        state <= S_IDLE;
      end
      if (ctl.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_dual_cmd: assert property (@(posedge clk) disable iff (rst)
    !(ctl.load && ctl.step))
    else $error("load and step issued together");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (state == S_DRAW))
    else $error("load did not start a line");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && sts.last) |=> (state == S_IDLE) && out_valid)
    else $error("final pixel did not end the line");

  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    ctl.step |=> out_valid)
    else $error("step produced no output beat");

endmodule

/* rtl/core/line_pixel_generator.sv */
// Top level of the line pixel generator: configuration port and block wiring.
//
// The block rasterizes straight lines into pixel coordinates. Items arrive on
// the item channel: a load (cmd 0) takes the two endpoints and starts a new
// line, dropping any line in progress, and produces no beat. Each step (cmd 1)
// produces one beat on the pixel channel with the current point, the draw
// color and a last flag; a step with no active line produces nothing. A line
// of major length L yields L + 2 beats, the start point appearing twice.
// The draw color register sits at byte address 0 of the APB port.
// A beat appears on the pixel channel in the cycle after its step is accepted.
// The block takes one item per cycle, the error update of a single step
// being done combinationally on the held line state. The output register frees
// the input side: an item is accepted whenever that register is empty or
// is being read in the same cycle, so a stalled receiver holds the input.
// Reset clears the color register and leaves no line active.
module line_pixel_generator #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  lpg_item_if.sink                          item,
  lpg_pixel_if.source                       pixel,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpg_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lpg_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lpg_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import lpg_pkg::*;

  logic [COLOR_BITS-1:0]   draw_color;
  logic [REG_IDX_BITS-1:0] reg_idx;
  lpg_cmd_t                ctl;
  lpg_sts_t                sts;

  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_DRAW_COLOR) ? APB_DATA_BITS'(draw_color) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= '0;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_DRAW_COLOR)) begin
      draw_color <= pwdata[COLOR_BITS-1:0];
    end
  end

  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_cmd    (item.cmd),
    .in_ready  (item.ready),
    .out_valid (pixel.valid),
    .out_ready (pixel.ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  lpg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .ctl         (ctl),
    .sts         (sts),
    .x_start     (item.x_start),
    .y_start     (item.y_start),
    .x_end       (item.x_end),
    .y_end       (item.y_end),
    .draw_color  (draw_color),
    .pixel_x     (pixel.pixel_x),
    .pixel_y     (pixel.pixel_y),
    .pixel_color (pixel.pixel_color),
    .last        (pixel.last)
  );

endmodule
